>>> sv/sstg_pkg.sv
// Shared types and constants for the Sierpinski subtriangle generator.
// No dependencies; imported by sstg_cell and sierpinski_subtriangle_gen_unit.
`default_nettype none

package sstg_pkg;

   // Width of the leaf index field
   localparam int unsigned IDX_BITS = 16;
   // Width of the configuration register index
   localparam int unsigned CSR_IDX_BITS = 3;
   // Width of the depth register
   localparam int unsigned DEPTH_REG_BITS = 4;
   // Width of the powers-of-three constants
   localparam int unsigned POW_BITS = 32;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CORNER0_X = 3'd0,
      CSR_CORNER0_Y = 3'd1,
      CSR_CORNER1_X = 3'd2,
      CSR_CORNER1_Y = 3'd3,
      CSR_CORNER2_X = 3'd4,
      CSR_CORNER2_Y = 3'd5,
      CSR_DEPTH     = 3'd6
   } csr_index_type;

   // Base-3 digit selecting the child triangle
   typedef enum logic [1:0] {
      DIGIT_CORNER0 = 2'd0,
      DIGIT_CORNER1 = 2'd1,
      DIGIT_CORNER2 = 2'd2
   } digit_type;

   // Control group handed from cell to cell with each request
   typedef struct packed {
      logic                valid;
      logic                too_large;
      logic [IDX_BITS-1:0] rem;
   } ctl_type;

   // 3^n, used only to build constants at elaboration
   function automatic logic [POW_BITS-1:0] pow3(input int unsigned n);
      logic [POW_BITS-1:0] p;
      p = POW_BITS'(1);
      for (int unsigned i = 0; i < n; i++) begin
         p = p * POW_BITS'(3);
      end
      return p;
   endfunction

endpackage

`default_nettype wire

>>> sv/sstg_cell.sv
// One subdivision level: takes a base-3 digit off the remaining index and
// replaces the triangle by the selected midpoint child. Depends on sstg_pkg.
`default_nettype none

module sstg_cell #(
   parameter int unsigned MAX_DEPTH  = 10,
   parameter int unsigned COORD_BITS = 24,
   parameter int unsigned LEVEL      = 1
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [$clog2(MAX_DEPTH+1)-1:0]       depth_sat,
   input  wire sstg_pkg::ctl_type                    up_ctl,
   input  wire logic [2:0][COORD_BITS-1:0]           up_px,
   input  wire logic [2:0][COORD_BITS-1:0]           up_py,
   output logic                                      up_stall,
   output sstg_pkg::ctl_type                         dn_ctl,
   output logic [2:0][COORD_BITS-1:0]                dn_px,
   output logic [2:0][COORD_BITS-1:0]                dn_py,
   input  wire logic                                 dn_stall
);
   import sstg_pkg::*;

   localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam logic [POW_BITS-1:0] P1 = pow3(LEVEL - 1);
   localparam logic [POW_BITS-1:0] P2 = P1 << 1;

   ctl_type                  ctl_ff, ctl_in;
   logic [2:0][COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic                     active;
   logic [POW_BITS-1:0]      rem_ext;
   digit_type                digit;
   logic [COORD_BITS:0]      s01x, s02x, s12x, s01y, s02y, s12y;
   logic [COORD_BITS-1:0]    m01x, m02x, m12x, m01y, m02y, m12y;
   logic                     take;

   // This level applies only when the configured depth reaches it
   assign active  = (depth_sat >= DEPTH_W'(LEVEL));
   assign rem_ext = POW_BITS'(up_ctl.rem);

   // Digit at this level: remaining index is below 3^LEVEL here
   always_comb begin
      if (rem_ext >= P2) begin
         digit = DIGIT_CORNER2;
      end else if (rem_ext >= P1) begin
         digit = DIGIT_CORNER1;
      end else begin
         digit = DIGIT_CORNER0;
      end
   end

   // Floor midpoints: sign-extended sum, drop the low bit
   assign s01x = {up_px[0][COORD_BITS-1], up_px[0]} + {up_px[1][COORD_BITS-1], up_px[1]};
   assign s02x = {up_px[0][COORD_BITS-1], up_px[0]} + {up_px[2][COORD_BITS-1], up_px[2]};
   assign s12x = {up_px[1][COORD_BITS-1], up_px[1]} + {up_px[2][COORD_BITS-1], up_px[2]};
   assign s01y = {up_py[0][COORD_BITS-1], up_py[0]} + {up_py[1][COORD_BITS-1], up_py[1]};
   assign s02y = {up_py[0][COORD_BITS-1], up_py[0]} + {up_py[2][COORD_BITS-1], up_py[2]};
   assign s12y = {up_py[1][COORD_BITS-1], up_py[1]} + {up_py[2][COORD_BITS-1], up_py[2]};
   assign m01x = s01x[COORD_BITS:1];
   assign m02x = s02x[COORD_BITS:1];
   assign m12x = s12x[COORD_BITS:1];
   assign m01y = s01y[COORD_BITS:1];
   assign m02y = s02y[COORD_BITS:1];
   assign m12y = s12y[COORD_BITS:1];

   // Child selection and index remainder
   always_comb begin
      ctl_in = up_ctl;
      px_in  = up_px;
      py_in  = up_py;
      if (active) begin
         case (digit)
            DIGIT_CORNER0: begin
               px_in[1] = m01x; py_in[1] = m01y;
               px_in[2] = m02x; py_in[2] = m02y;
            end
            DIGIT_CORNER1: begin
               ctl_in.rem = IDX_BITS'(rem_ext - P1);
               px_in[0] = m01x; py_in[0] = m01y;
               px_in[2] = m12x; py_in[2] = m12y;
            end
            DIGIT_CORNER2: begin
               ctl_in.rem = IDX_BITS'(rem_ext - P2);
               px_in[0] = m02x; py_in[0] = m02y;
               px_in[1] = m12x; py_in[1] = m12y;
            end
            default: begin
               ctl_in = up_ctl;
            end
         endcase
      end
   end

   // Stage moves when empty or when the next stage takes its request
   assign up_stall = ctl_ff.valid && dn_stall;
   assign take     = !up_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (take) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && up_ctl.valid) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_px  = px_ff;
   assign dn_py  = py_ff;

endmodule

`default_nettype wire

>>> sv/sierpinski_subtriangle_gen_unit.sv
// Sierpinski subtriangle generator: one leaf index in, the leaf's three
// corners out. A request may enter every cycle while req_stall is low; each
// one passes through a row of MAX_DEPTH cells, one per subdivision level
// from the top, and its result is held in the last cell. Each cell holds its
// own request, so bubbles close up and requests keep entering while a
// finished result waits on rsp_stall, until every cell is full. Levels above
// the configured depth pass the triangle through unchanged. An index of
// 3^depth or more gives zero corners with index_too_large set. Depth above
// MAX_DEPTH acts as MAX_DEPTH. Write configuration only while no request
// is in flight. Depends on sstg_pkg and sstg_cell.
`default_nettype none

module sierpinski_subtriangle_gen_unit #(
   parameter int unsigned MAX_DEPTH  = 10,
   parameter int unsigned COORD_BITS = 24
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration write port
   input  wire logic                               csr_we,
   input  wire logic [sstg_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [COORD_BITS-1:0]              csr_wdata,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [sstg_pkg::IDX_BITS-1:0]      req_leaf_index,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [COORD_BITS-1:0]            rsp_vert0_x,
   output logic signed [COORD_BITS-1:0]            rsp_vert0_y,
   output logic signed [COORD_BITS-1:0]            rsp_vert1_x,
   output logic signed [COORD_BITS-1:0]            rsp_vert1_y,
   output logic signed [COORD_BITS-1:0]            rsp_vert2_x,
   output logic signed [COORD_BITS-1:0]            rsp_vert2_y,
   output logic                                    rsp_index_too_large
);
   import sstg_pkg::*;

   localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);

   logic [2:0][COORD_BITS-1:0] corner_x_ff, corner_y_ff;
   logic [DEPTH_REG_BITS-1:0]  depth_ff;
   logic [DEPTH_W-1:0]         depth_sat;
   logic [POW_BITS-1:0]        pow3_tab [0:MAX_DEPTH];
   logic                       too_large;

   ctl_type                    ctl   [0:MAX_DEPTH];
   logic [2:0][COORD_BITS-1:0] px    [0:MAX_DEPTH];
   logic [2:0][COORD_BITS-1:0] py    [0:MAX_DEPTH];
   logic                       stall [0:MAX_DEPTH];

   // Configuration registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         corner_x_ff <= '0;
         corner_y_ff <= '0;
         depth_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CORNER0_X: corner_x_ff[0] <= csr_wdata;
            CSR_CORNER0_Y: corner_y_ff[0] <= csr_wdata;
            CSR_CORNER1_X: corner_x_ff[1] <= csr_wdata;
            CSR_CORNER1_Y: corner_y_ff[1] <= csr_wdata;
            CSR_CORNER2_X: corner_x_ff[2] <= csr_wdata;
            CSR_CORNER2_Y: corner_y_ff[2] <= csr_wdata;
            CSR_DEPTH:     depth_ff       <= csr_wdata[DEPTH_REG_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Saturate depth to the number of cells
   always_comb begin
      if (32'(depth_ff) > MAX_DEPTH) begin
         depth_sat = DEPTH_W'(MAX_DEPTH);
      end else begin
         depth_sat = DEPTH_W'(depth_ff);
      end
   end

   // Leaf count per depth, constant table
   for (genvar g = 0; g <= MAX_DEPTH; g++) begin : g_pow
      assign pow3_tab[g] = pow3(g);
   end

   assign too_large = (POW_BITS'(req_leaf_index) >= pow3_tab[depth_sat]);

   // Entry: out-of-range requests travel as a zero triangle
   assign ctl[0].valid     = req_valid;
   assign ctl[0].too_large = too_large;
   assign ctl[0].rem       = req_leaf_index;
   assign px[0]            = too_large ? '0 : corner_x_ff;
   assign py[0]            = too_large ? '0 : corner_y_ff;
   assign req_stall        = stall[0];

   // Row of level cells, top level first
   for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
      sstg_cell #(
         .MAX_DEPTH  (MAX_DEPTH),
         .COORD_BITS (COORD_BITS),
         .LEVEL      (MAX_DEPTH - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .depth_sat (depth_sat),
         .up_ctl    (ctl[i]),
         .up_px     (px[i]),
         .up_py     (py[i]),
         .up_stall  (stall[i]),
         .dn_ctl    (ctl[i+1]),
         .dn_px     (px[i+1]),
         .dn_py     (py[i+1]),
         .dn_stall  (stall[i+1])
      );
   end

   // Last cell is the result register
   assign stall[MAX_DEPTH]   = rsp_stall;
   assign rsp_valid          = ctl[MAX_DEPTH].valid;
   assign rsp_index_too_large = ctl[MAX_DEPTH].too_large;
   assign rsp_vert0_x        = px[MAX_DEPTH][0];
   assign rsp_vert0_y        = py[MAX_DEPTH][0];
   assign rsp_vert1_x        = px[MAX_DEPTH][1];
   assign rsp_vert1_y        = py[MAX_DEPTH][1];
   assign rsp_vert2_x        = px[MAX_DEPTH][2];
   assign rsp_vert2_y        = py[MAX_DEPTH][2];

endmodule

`default_nettype wire

>>> sv/sstg_checker.sv
// Port-level checks for the Sierpinski subtriangle generator, and the bind
// that attaches them to sierpinski_subtriangle_gen_unit.
`default_nettype none

module sstg_checker #(
   parameter int unsigned COORD_BITS = 24
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_stall,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire logic [COORD_BITS-1:0]   rsp_vert0_x,
   input wire logic [COORD_BITS-1:0]   rsp_vert0_y,
   input wire logic [COORD_BITS-1:0]   rsp_vert1_x,
   input wire logic [COORD_BITS-1:0]   rsp_vert1_y,
   input wire logic [COORD_BITS-1:0]   rsp_vert2_x,
   input wire logic [COORD_BITS-1:0]   rsp_vert2_y,
   input wire logic                    rsp_index_too_large
);

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Out-of-range leaf comes back as a zero triangle
   a_zero_corners: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_too_large) |->
         (rsp_vert0_x == '0 && rsp_vert0_y == '0 && rsp_vert1_x == '0 &&
          rsp_vert1_y == '0 && rsp_vert2_x == '0 && rsp_vert2_y == '0))
      else $error("too-large index with nonzero corners");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_vert0_x) &&
         $stable(rsp_vert1_y) && $stable(rsp_index_too_large)))
      else $error("stalled result changed");

   // Input never stalls while the result side is free
   a_no_stall_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_stall) |-> !req_stall)
      else $error("request stalled with result side free");

endmodule

bind sierpinski_subtriangle_gen_unit sstg_checker #(
   .COORD_BITS (COORD_BITS)
) u_sstg_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_vert0_x         (rsp_vert0_x),
   .rsp_vert0_y         (rsp_vert0_y),
   .rsp_vert1_x         (rsp_vert1_x),
   .rsp_vert1_y         (rsp_vert1_y),
   .rsp_vert2_x         (rsp_vert2_x),
   .rsp_vert2_y         (rsp_vert2_y),
   .rsp_index_too_large (rsp_index_too_large)
);

`default_nettype wire

>>> tb/sv/sstg_result_checker.sv
// Scoreboard for the Sierpinski subtriangle generator: snoops the config port,
// predicts each leaf's corners, and compares them against the result channel.
// Depends on sstg_pkg.
`timescale 1ns / 1ps

module sstg_result_checker #(
   parameter int unsigned MAX_DEPTH  = 10,
   parameter int unsigned COORD_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [sstg_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [COORD_BITS-1:0]                 csr_wdata,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic [sstg_pkg::IDX_BITS-1:0]         req_leaf_index,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [COORD_BITS-1:0]          rsp_vert0_x,
   input  logic signed [COORD_BITS-1:0]          rsp_vert0_y,
   input  logic signed [COORD_BITS-1:0]          rsp_vert1_x,
   input  logic signed [COORD_BITS-1:0]          rsp_vert1_y,
   input  logic signed [COORD_BITS-1:0]          rsp_vert2_x,
   input  logic signed [COORD_BITS-1:0]          rsp_vert2_y,
   input  logic                                  rsp_index_too_large,
   output int                                    fail_count,
   output int                                    pending_count
);
   import sstg_pkg::*;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] vert0_x;
      logic signed [COORD_BITS-1:0] vert0_y;
      logic signed [COORD_BITS-1:0] vert1_x;
      logic signed [COORD_BITS-1:0] vert1_y;
      logic signed [COORD_BITS-1:0] vert2_x;
      logic signed [COORD_BITS-1:0] vert2_y;
      logic                         too_large;
   } leaf_corners_type;

   // shadow copy of the configuration registers
   logic signed [COORD_BITS-1:0] root_x [3];
   logic signed [COORD_BITS-1:0] root_y [3];
   logic [DEPTH_REG_BITS-1:0]    depth_reg;

   leaf_corners_type expected_leaves [$];
   leaf_corners_type want;
   int               mismatches = 0;

   assign fail_count = mismatches;

   // Walk the base-3 digits of the index, top level first, halving toward
   // minus infinity at each level.
   function automatic leaf_corners_type predict_leaf_corners(input logic [IDX_BITS-1:0] leaf);
      leaf_corners_type res;
      longint           vx [3];
      longint           vy [3];
      longint           m01x, m01y, m02x, m02y, m12x, m12y;
      longint unsigned  span;
      int unsigned      levels;
      int               l;
      digit_type        digit;
      res = '0;
      levels = (depth_reg > MAX_DEPTH) ? MAX_DEPTH : depth_reg;
      span = 1;
      for (l = 0; l < levels; l++) span = span * 3;
      if (leaf >= span) begin
         res.too_large = 1'b1;
         return res;
      end
      for (l = 0; l < 3; l++) begin
         vx[l] = root_x[l];
         vy[l] = root_y[l];
      end
      for (l = levels; l > 0; l--) begin
         span  = span / 3;
         digit = digit_type'(2'((leaf / span) % 3));
         m01x  = (vx[0] + vx[1]) >>> 1;
         m01y  = (vy[0] + vy[1]) >>> 1;
         m02x  = (vx[0] + vx[2]) >>> 1;
         m02y  = (vy[0] + vy[2]) >>> 1;
         m12x  = (vx[1] + vx[2]) >>> 1;
         m12y  = (vy[1] + vy[2]) >>> 1;
         case (digit)
            DIGIT_CORNER0: begin
               vx[1] = m01x; vy[1] = m01y;
               vx[2] = m02x; vy[2] = m02y;
            end
            DIGIT_CORNER1: begin
               vx[0] = m01x; vy[0] = m01y;
               vx[2] = m12x; vy[2] = m12y;
            end
            default: begin
               vx[0] = m02x; vy[0] = m02y;
               vx[1] = m12x; vy[1] = m12y;
            end
         endcase
      end
      res.vert0_x = COORD_BITS'(vx[0]);
      res.vert0_y = COORD_BITS'(vy[0]);
      res.vert1_x = COORD_BITS'(vx[1]);
      res.vert1_y = COORD_BITS'(vy[1]);
      res.vert2_x = COORD_BITS'(vx[2]);
      res.vert2_y = COORD_BITS'(vy[2]);
      return res;
   endfunction

   task automatic check_field(input string name, input logic signed [COORD_BITS-1:0] exp_val,
                              input logic signed [COORD_BITS-1:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 3; j++) begin
            root_x[j] = '0;
            root_y[j] = '0;
         end
         depth_reg = '0;
         expected_leaves.delete();
      end else begin
         // config snoop; unmapped indexes are dropped
         if (csr_we) begin
            case (csr_index)
               CSR_CORNER0_X: root_x[0] = csr_wdata;
               CSR_CORNER0_Y: root_y[0] = csr_wdata;
               CSR_CORNER1_X: root_x[1] = csr_wdata;
               CSR_CORNER1_Y: root_y[1] = csr_wdata;
               CSR_CORNER2_X: root_x[2] = csr_wdata;
               CSR_CORNER2_Y: root_y[2] = csr_wdata;
               CSR_DEPTH:     depth_reg = csr_wdata[DEPTH_REG_BITS-1:0];
               default: ;
            endcase
         end
         // results first, so a same-cycle request can never match itself
         if (rsp_valid && !rsp_stall) begin
            if (expected_leaves.size() == 0) begin
               $error("result accepted with no request outstanding");
               mismatches++;
            end else begin
               want = expected_leaves.pop_front();
               check_field("vert0_x", want.vert0_x, rsp_vert0_x);
               check_field("vert0_y", want.vert0_y, rsp_vert0_y);
               check_field("vert1_x", want.vert1_x, rsp_vert1_x);
               check_field("vert1_y", want.vert1_y, rsp_vert1_y);
               check_field("vert2_x", want.vert2_x, rsp_vert2_x);
               check_field("vert2_y", want.vert2_y, rsp_vert2_y);
               check_field("index_too_large", want.too_large, rsp_index_too_large);
            end
         end
         if (req_valid && !req_stall)
            expected_leaves.insert(expected_leaves.size(),
                                   predict_leaf_corners(req_leaf_index));
      end
      pending_count <= expected_leaves.size();
   end

endmodule

>>> tb/sv/tb_top.sv
// Top of the subtriangle generator bench: clock, reset, config writes, request
// and stall stimulus, and the verdict. Depends on sstg_pkg,
// sierpinski_subtriangle_gen_unit and sstg_result_checker.
`timescale 1ns / 1ps

module tb_top;
   import sstg_pkg::*;

   localparam int unsigned MAX_DEPTH   = 10;
   localparam int unsigned COORD_BITS  = 24;
   localparam int          HOLD_CYCLES = 300;
   localparam int          CYCLE_LIMIT = 400000;
   // index with no register behind it
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED = 3'd7;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]      csr_index = '0;
   logic [COORD_BITS-1:0]        csr_wdata = '0;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [IDX_BITS-1:0]          req_leaf_index = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [COORD_BITS-1:0] rsp_vert0_x, rsp_vert0_y;
   logic signed [COORD_BITS-1:0] rsp_vert1_x, rsp_vert1_y;
   logic signed [COORD_BITS-1:0] rsp_vert2_x, rsp_vert2_y;
   logic                         rsp_index_too_large;
   int                           fail_count;
   int                           pending_count;

   int send_idle_pct = 21;
   int recv_idle_pct = 51;
   bit hold_pending  = 1'b0;
   int hold_count;
   int cycle_count   = 0;

   sierpinski_subtriangle_gen_unit #(
      .MAX_DEPTH (MAX_DEPTH),
      .COORD_BITS(COORD_BITS)
   ) dut (.*);

   sstg_result_checker #(
      .MAX_DEPTH (MAX_DEPTH),
      .COORD_BITS(COORD_BITS)
   ) checker_inst (.*);

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: random stalls, or one long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic send_leaf(input logic [IDX_BITS-1:0] leaf);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_leaf_index <= leaf;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid and wait for every outstanding request to come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic csr_put(input logic [CSR_IDX_BITS-1:0] idx, input logic [COORD_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [COORD_BITS-1:0] x0, y0, x1, y1, x2, y2,
                             input logic [DEPTH_REG_BITS-1:0] dep);
      wait_idle();
      csr_put(CSR_CORNER0_X, x0);
      csr_put(CSR_CORNER0_Y, y0);
      csr_put(CSR_CORNER1_X, x1);
      csr_put(CSR_CORNER1_Y, y1);
      csr_put(CSR_CORNER2_X, x2);
      csr_put(CSR_CORNER2_Y, y2);
      csr_put(CSR_DEPTH, COORD_BITS'(dep));
      // junk to the unmapped index must change nothing
      csr_put(CSR_UNMAPPED, COORD_BITS'($urandom));
      csr_we <= 1'b0;
   endtask

   // coordinates biased toward the range ends
   function automatic logic [COORD_BITS-1:0] rand_coord();
      case ($urandom_range(7))
         0:       return 24'h800000;
         1:       return 24'h7FFFFF;
         2:       return 24'h000000;
         3:       return 24'hFFFFFF;
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   initial begin
      int unsigned               span;
      logic [DEPTH_REG_BITS-1:0] dep;
      logic [IDX_BITS-1:0]       leaf;
      int                        phase;
      int                        n;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset config: depth zero, degenerate root at the origin
      send_leaf(16'd0);
      send_leaf(16'd1);

      // depth zero with extreme corners: root comes back as-is
      set_config(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 4'd0);
      send_leaf(16'd0);
      send_leaf(16'hFFFF);

      // depth above the max saturates to ten levels
      set_config(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 4'd15);
      send_leaf(16'd0);
      send_leaf(16'd1);
      send_leaf(16'd2);
      send_leaf(16'd19683);
      send_leaf(16'd39366);
      send_leaf(16'd59048);
      send_leaf(16'd59049);
      send_leaf(16'hFFFF);
      send_leaf(16'h8000);
      send_leaf(16'h5555);
      send_leaf(16'hAAAA);

      // one level, odd sums with negatives exercise floor rounding
      set_config(24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h000000, 24'h800000, 4'd1);
      send_leaf(16'd0);
      send_leaf(16'd1);
      send_leaf(16'd2);
      send_leaf(16'd3);

      // random phases: sender-light, receiver-light, then no idling
      for (phase = 0; phase < 6; phase++) begin
         dep = (phase % 2 == 0) ? 4'd10 : DEPTH_REG_BITS'($urandom_range(15));
         set_config(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), dep);
         send_idle_pct = (phase < 2) ? 21 : (phase < 4) ? 51 : 0;
         recv_idle_pct = (phase < 2) ? 51 : (phase < 4) ? 21 : 0;
         span = 1;
         for (n = 0; n < ((dep > MAX_DEPTH) ? MAX_DEPTH : dep); n++) span = span * 3;
         // long receiver hold-off while requests keep coming
         if (phase == 5) hold_pending = 1'b1;
         for (n = 0; n < 285; n++) begin
            if (phase == 3 && n == 140) wait_idle();
            if ($urandom_range(9) < 8) leaf = IDX_BITS'($urandom_range(span - 1));
            else leaf = IDX_BITS'($urandom_range(16'hFFFF));
            send_leaf(leaf);
         end
      end

      wait_idle();
      repeat (MAX_DEPTH * 2) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
